// ===== src/fpfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fixed partition fit allocator.
// No dependencies; used by fpfa_cell and fixed_partition_fit_allocator.
package fpfa_pkg;

  localparam int SIZE_W = 10;
  localparam int SLOT_W = 4;
  localparam int IDX_W  = 6;
  localparam int POL_W  = 2;
  localparam int CNT_W  = 5;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_PARTS      = 1'b1;

  localparam logic [CNT_W-1:0] PARTS_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] want;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } scan_t;

endpackage

// ===== src/fpfa_cell.sv =====
`timescale 1ns / 1ps
// One partition cell: holds a size and a used mark, updates the passing scan token.
// Depends on fpfa_pkg.
module fpfa_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fpfa_pkg::scan_t            tok_in,
  input  logic                       en,
  input  logic [fpfa_pkg::POL_W-1:0] policy,
  input  logic                       wr_en,
  input  logic [fpfa_pkg::SIZE_W-1:0] wr_size,
  input  logic                       set_used,
  input  logic                       clr_used,
  output fpfa_pkg::scan_t            tok_out,
  output logic                       used
);
  import fpfa_pkg::*;

  logic [SIZE_W-1:0] size;
  logic              fits;
  logic              take;
  scan_t             tok_next;

  always_comb begin
    fits = en && !used && (size >= tok_in.want);
    take = fits && (!tok_in.found ||
                    ((policy == POL_BEST) && (size < tok_in.size)) ||
                    ((policy == POL_WORST) && (size > tok_in.size)));
    tok_next = tok_in;
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.idx   = IDX_W'(CELL_IDX);
      tok_next.size  = size;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      size <= wr_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (clr_used) begin
      used <= 1'b0;
    end else if (set_used) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.want  <= tok_next.want;
    tok_out.found <= tok_next.found;
    tok_out.idx   <= tok_next.idx;
    tok_out.size  <= tok_next.size;
  end

endmodule

// ===== src/fixed_partition_fit_allocator.sv =====
`timescale 1ns / 1ps
// Top level: APB registers, item control and the chain of partition cells.
// Depends on fpfa_pkg and fpfa_cell.
//
//   channel | signals                                        | direction
//   input   | in_valid/in_ready, req_type slot amount batch_end | in
//   output  | out_valid/out_ready, granted granted_slot granted_size | out
//   config  | psel penable pwrite paddr pwdata prdata pready  | APB
//
// A load item goes from idle straight to the finish step; an allocate item first
// passes the scan step, the scan token stepping through one cell per cycle.
// One item is in work at a time; the next is accepted while a result waits.
// A waiting result stalls only the finish step, not acceptance of the next item.
// Reset is synchronous and frees every partition; sizes are undefined until loaded.
module fixed_partition_fit_allocator #(
  parameter int NUM_PARTITIONS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [fpfa_pkg::SLOT_W-1:0] slot,
  input  logic [fpfa_pkg::SIZE_W-1:0] amount,
  input  logic                        batch_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        granted,
  output logic [fpfa_pkg::SLOT_W-1:0] granted_slot,
  output logic [fpfa_pkg::SIZE_W-1:0] granted_size,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fpfa_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [POL_W-1:0]  fit_policy;
  logic [CNT_W-1:0]  partitions_in_use;
  logic              item_batch_end;
  logic              res_found;
  logic [IDX_W-1:0]  res_idx;
  logic [SIZE_W-1:0] res_size;
  logic              in_fire;
  logic              finish_fire;
  logic              cfg_wr;

  scan_t                   tok [0:NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] tok_busy;
  logic [NUM_PARTITIONS-1:0] used_vec;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy        <= POL_FIRST;
      partitions_in_use <= PARTS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIT_POLICY) begin
        fit_policy <= pwdata[POL_W-1:0];
      end else begin
        partitions_in_use <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_PARTS) begin
      prdata = {{(32-CNT_W){1'b0}}, partitions_in_use};
    end else begin
      prdata = {{(32-POL_W){1'b0}}, fit_policy};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_ALLOC) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (tok[NUM_PARTITIONS].valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    in_fire     = in_ready && in_valid;
    finish_fire = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_batch_end <= batch_end;
      res_found      <= 1'b0;
      res_idx        <= '0;
      res_size       <= '0;
    end else if ((state == ST_SCAN) && tok[NUM_PARTITIONS].valid) begin
      res_found <= tok[NUM_PARTITIONS].found;
      res_idx   <= tok[NUM_PARTITIONS].idx;
      res_size  <= tok[NUM_PARTITIONS].size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (finish_fire) begin
      granted      <= res_found;
      granted_slot <= res_idx[SLOT_W-1:0];
      granted_size <= res_size;
    end
  end

  always_comb begin
    tok[0].valid = in_fire && (req_type == REQ_ALLOC);
    tok[0].want  = amount;
    tok[0].found = 1'b0;
    tok[0].idx   = '0;
    tok[0].size  = '0;
  end

  for (genvar i = 0; i < NUM_PARTITIONS; i++) begin : g_cell
    logic cell_en;
    logic cell_wr;
    logic cell_set;

    assign cell_en  = int'(partitions_in_use) > i;
    assign cell_wr  = in_fire && (req_type == REQ_LOAD) && (int'(slot) == i);
    assign cell_set = finish_fire && res_found && (res_idx == IDX_W'(i));
    assign tok_busy[i] = tok[i+1].valid;

    fpfa_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .en       (cell_en),
      .policy   (fit_policy),
      .wr_en    (cell_wr),
      .wr_size  (amount),
      .set_used (cell_set),
      .clr_used (finish_fire && item_batch_end),
      .tok_out  (tok[i+1]),
      .used     (used_vec[i])
    );
  end

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[NUM_PARTITIONS].valid |-> state == ST_SCAN)
    else $error("scan token left the chain outside a scan");

  a_chain_empty_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> tok_busy == '0)
    else $error("scan token still in the chain while idle");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (granted_slot == '0) && (granted_size == '0))
    else $error("refused item carries a slot or size");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (finish_fire && item_batch_end) |=> used_vec == '0)
    else $error("batch end left a partition marked used");

endmodule

// ===== tb/fixed_partition_fit_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fixed_partition_fit_allocator: load and allocate items
// under first, best and worst fit, with random stalls and register changes between phases.
// Depends on fpfa_pkg and the allocator RTL.
module fixed_partition_fit_allocator_tb;
  import fpfa_pkg::*;

  localparam int NUM_PARTITIONS = 16;
  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 45;

  typedef struct packed {
    logic              req;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] amount;
    logic              batch;
  } req_item_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              req_type = REQ_LOAD;
  logic [SLOT_W-1:0] slot = '0;
  logic [SIZE_W-1:0] amount = '0;
  logic              batch_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              granted;
  logic [SLOT_W-1:0] granted_slot;
  logic [SIZE_W-1:0] granted_size;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  req_item_t         pending_requests[$];
  grant_t            pending_grants[$];

  logic [SIZE_W-1:0] size_tbl [NUM_PARTITIONS];
  bit                used_tbl [NUM_PARTITIONS];
  logic [POL_W-1:0]  cfg_policy = POL_FIRST;
  logic [CNT_W-1:0]  cfg_parts = PARTS_RESET;

  int  send_idle_pct = 6;
  int  recv_idle_pct = 77;
  bit  hold_arm = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;
  int  mismatch_count = 0;
  bit  apb_write_edge;

  fixed_partition_fit_allocator #(.NUM_PARTITIONS(NUM_PARTITIONS)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic grant_t predict_grant(req_item_t it);
    grant_t res;
    int     n;
    int     pick;
    logic [SIZE_W-1:0] pick_size;
    res = '0;
    pick = -1;
    pick_size = '0;
    if (it.req == REQ_LOAD) begin
      size_tbl[it.slot] = it.amount;
    end else begin
      n = (cfg_parts > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(cfg_parts);
      for (int i = 0; i < n; i++) begin
        if (used_tbl[i] || size_tbl[i] < it.amount) continue;
        if (pick < 0) begin
          pick = i;
          pick_size = size_tbl[i];
          if (cfg_policy != POL_BEST && cfg_policy != POL_WORST) break;
        end else if (cfg_policy == POL_BEST && size_tbl[i] < pick_size) begin
          pick = i;
          pick_size = size_tbl[i];
        end else if (cfg_policy == POL_WORST && size_tbl[i] > pick_size) begin
          pick = i;
          pick_size = size_tbl[i];
        end
      end
      if (pick >= 0) begin
        used_tbl[pick] = 1'b1;
        res.granted = 1'b1;
        res.slot = SLOT_W'(pick);
        res.size = pick_size;
      end
    end
    if (it.batch) begin
      foreach (used_tbl[i]) used_tbl[i] = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        req_type  <= pending_requests[0].req;
        slot      <= pending_requests[0].slot;
        amount    <= pending_requests[0].amount;
        batch_end <= pending_requests[0].batch;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_cnt  <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    grant_t    exp_res;
    req_item_t acc;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: granted=%0d slot=%0d size=%0d",
                     granted, granted_slot, granted_size);
        end else begin
          exp_res = pending_grants.pop_front();
          if (granted !== exp_res.granted || granted_slot !== exp_res.slot ||
              granted_size !== exp_res.size) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected granted=%0d slot=%0d size=%0d, got %0d %0d %0d",
                       exp_res.granted, exp_res.slot, exp_res.size,
                       granted, granted_slot, granted_size);
          end
        end
      end
      if (in_valid && in_ready) begin
        acc = '{req: req_type, slot: slot, amount: amount, batch: batch_end};
        pending_grants.push_back(predict_grant(acc));
      end
      apb_write_edge = psel && penable && pwrite && pready;
      if ((in_valid && in_ready) || (out_valid && out_ready) || apb_write_edge) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[fixed_partition_fit_allocator] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic reg_write(input logic reg_sel, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_FIT_POLICY) cfg_policy = value[POL_W-1:0];
    else cfg_parts = value[CNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || pending_grants.size() != 0);
  endtask

  task automatic push_req(input logic req, input int s, input int amt, input logic be);
    req_item_t it;
    it.req = req;
    it.slot = SLOT_W'(s);
    it.amount = SIZE_W'(amt);
    it.batch = be;
    pending_requests.push_back(it);
  endtask

  initial begin
    int load_sizes [NUM_PARTITIONS];
    int phase_policy [PHASES];
    int phase_parts  [PHASES];
    int r;
    int amt;
    load_sizes   = '{100, 0, 1023, 50, 512, 100, 1, 300,
                     1023, 200, 50, 700, 341, 682, 5, 999};
    phase_policy = '{1, 2, 0, 3, 1, 2, 0, 1, 2};
    phase_parts  = '{16, 16, 0, 17, 1, 31, 16, 8, 5};
    foreach (size_tbl[i]) size_tbl[i] = '0;
    foreach (used_tbl[i]) used_tbl[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_PARTITIONS; i++)
      push_req(REQ_LOAD, i, load_sizes[i], i == NUM_PARTITIONS - 1);
    push_req(REQ_ALLOC, 0, 0, 1'b0);
    push_req(REQ_ALLOC, 0, 1023, 1'b0);
    push_req(REQ_ALLOC, 0, 1023, 1'b0);
    push_req(REQ_ALLOC, 0, 1023, 1'b0);
    push_req(REQ_ALLOC, 0, 60, 1'b1);
    wait_drained();

    reg_write(REG_FIT_POLICY, 32'(POL_BEST));
    @(negedge clk);
    push_req(REQ_ALLOC, 0, 0, 1'b0);
    push_req(REQ_ALLOC, 0, 50, 1'b0);
    push_req(REQ_ALLOC, 0, 50, 1'b0);
    push_req(REQ_ALLOC, 0, 50, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 6;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      reg_write(REG_FIT_POLICY, 32'(phase_policy[p]));
      reg_write(REG_PARTS, 32'(phase_parts[p]));
      @(negedge clk);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 30) begin
          case ($urandom_range(3))
            0:       amt = size_tbl[$urandom_range(NUM_PARTITIONS - 1)];
            1:       amt = $urandom_range(63);
            default: amt = $urandom_range(1023);
          endcase
          push_req(REQ_LOAD, $urandom_range(NUM_PARTITIONS - 1), amt,
                   $urandom_range(9) == 0);
        end else begin
          r = $urandom_range(99);
          if (r < 40)      amt = $urandom_range(1023);
          else if (r < 70) amt = size_tbl[$urandom_range(NUM_PARTITIONS - 1)];
          else if (r < 90) amt = $urandom_range(63);
          else             amt = 0;
          push_req(REQ_ALLOC, 0, amt, $urandom_range(9) == 0);
        end
      end
      if (p == 6) hold_arm = ~hold_arm;
      wait_drained();
    end

    repeat (NUM_PARTITIONS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("[fixed_partition_fit_allocator] OK");
    end else begin
      $display("[fixed_partition_fit_allocator] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fpfa_pkg.sv
src/fpfa_cell.sv
src/fixed_partition_fit_allocator.sv
tb/fixed_partition_fit_allocator_tb.sv
